@@ rtl/ole_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg
// Widths, reset values, register indexes and arithmetic constants shared by
// the optical lag envelope follower and its stream interfaces.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int LIGHT_W = 24;   // signed light sample, 1.0 = 2^20
    localparam int ENV_W   = 17;   // Q0.16 envelope, 0..65536
    localparam int COEF_W  = 25;   // Q0.24 coefficients
    localparam int GAMMA_W = 20;   // Q3.16 gamma
    localparam int GAIN_W  = 19;   // Q2.16 gain
    localparam int LEVEL_W = 25;   // Q0.24 smoothed level
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int REG_IDX_W = 2;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAMMA   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN    = 2'd3;

    localparam logic [LEVEL_W-1:0] Q24_ONE     = 25'd16777216;
    localparam logic [COEF_W-1:0]  ATTACK_RST  = 25'd16777216;
    localparam logic [COEF_W-1:0]  RELEASE_RST = 25'd3495;
    localparam logic [GAMMA_W-1:0] GAMMA_RST   = 20'd65536;
    localparam logic [GAMMA_W-1:0] GAMMA_MIN   = 20'd66;
    localparam logic [GAIN_W-1:0]  GAIN_RST    = 19'd65536;
    localparam logic [ENV_W-1:0]   OUT_ONE     = 17'd65536;

    // rounding constant for the Q0.24 step (half an LSB)
    localparam logic [48:0] ROUND_HALF = 49'd8388608;
    // log2 offset of the power approximation
    localparam logic signed [MUL_W-1:0] MANT_OFFS = 26'sd60801;
    // exponent bias minus offset, pre-scaled by 2^16
    localparam logic signed [PROD_W:0] POW_BIAS_Q16 = 53'sd1072632447 <<< 16;
    localparam logic [10:0] EXP_ONE   = 11'd1023;
    localparam logic [10:0] EXP_FLOOR = 11'd1007;
    localparam logic [10:0] EXP_SHIFT = 11'd1027;

endpackage

@@ rtl/ole_light_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_light_if
// Valid/ready stream carrying one light sample per transfer.
// ----------------------------------------------------------------------------
interface ole_light_if;
    import ole_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [LIGHT_W-1:0] light_level;

    modport source (output valid, output light_level, input ready);
    modport sink   (input valid, input light_level, output ready);

endinterface

@@ rtl/ole_env_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_env_if
// Valid/ready stream carrying one shaped envelope value per transfer.
// ----------------------------------------------------------------------------
interface ole_env_if;
    import ole_pkg::*;

    logic             valid;
    logic             ready;
    logic [ENV_W-1:0] envelope_out;

    modport source (output valid, output envelope_out, input ready);
    modport sink   (input valid, input envelope_out, output ready);

endinterface

@@ rtl/optical_lag_envelope.sv @@
`timescale 1ns / 1ps
// Each sample runs TGT, DIFF, STEP, UPD, NORM passes, POW, FIN; at zero level UPD
// goes straight to FIN. A new sample is taken only when idle, after the last
// result entered the output register. The single shared 26x26 multiplier is used
// three times per sample (twice at zero level); the leading-one search takes five
// shift passes. Reset (rst_n, async, active low): sequencer idle, output
// empty, smoothed level 0, registers at their defaults.
// ----------------------------------------------------------------------------
// optical_lag_envelope
// One-pole attack/release envelope follower with a log-linear gamma curve,
// run by a small sequencer around one shared multiplier. APB register port.
// ----------------------------------------------------------------------------
module optical_lag_envelope (
    input  logic                        clk,
    input  logic                        rst_n,
    ole_light_if.sink                   light,
    ole_env_if.source                   env,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ole_pkg::ADDR_W-1:0]  paddr,
    input  logic [ole_pkg::DATA_W-1:0]  pwdata,
    output logic [ole_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import ole_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TGT  = 4'd1;
    localparam logic [3:0] S_DIFF = 4'd2;
    localparam logic [3:0] S_STEP = 4'd3;
    localparam logic [3:0] S_UPD  = 4'd4;
    localparam logic [3:0] S_NORM = 4'd5;
    localparam logic [3:0] S_POW  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;

    localparam logic [2:0] LAST_PASS = 3'd4;

    // configuration
    logic [COEF_W-1:0]  attack_reg;
    logic [COEF_W-1:0]  release_reg;
    logic [GAMMA_W-1:0] gamma_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic               cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // sequencer and datapath
    logic [3:0]                state_reg, state_next;
    logic signed [LIGHT_W-1:0] light_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [LEVEL_W-1:0]        level_reg, level_next;
    logic [LEVEL_W-1:0]        d_reg;
    logic [COEF_W-1:0]         coef_reg;
    logic                      up_reg;
    logic                      zero_reg;
    logic [LEVEL_W-1:0]        norm_reg;
    logic [4:0]                shift_reg;
    logic [2:0]                pass_reg;
    logic                      out_valid_reg;
    logic [ENV_W-1:0]          env_reg, env_next;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    logic                      light_pos;
    logic [29:0]               tgt_raw;
    logic [LEVEL_W-1:0]        target, level_c;
    logic                      up_c;
    logic [COEF_W-1:0]         coef_c;
    logic [48:0]               rnd_sum;
    logic [LEVEL_W-1:0]        step;
    logic                      top_zero;
    logic [4:0]                amt;
    logic signed [MUL_W-1:0]   x_val;
    logic [GAMMA_W-1:0]        gamma_eff;
    logic signed [PROD_W:0]    acc;
    logic [10:0]               exp_bits;
    logic [19:0]               mant;
    logic [10:0]               sh_full;
    logic [20:0]               shifted;
    logic                      in_xfer, out_load;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= ATTACK_RST;
            release_reg <= RELEASE_RST;
            gamma_reg   <= GAMMA_RST;
            gain_reg    <= GAIN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ATTACK:  attack_reg  <= pwdata[COEF_W-1:0];
                REG_RELEASE: release_reg <= pwdata[COEF_W-1:0];
                REG_GAMMA:   gamma_reg   <= pwdata[GAMMA_W-1:0];
                REG_GAIN:    gain_reg    <= pwdata[GAIN_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ATTACK:  prdata = {{(DATA_W-COEF_W){1'b0}}, attack_reg};
            REG_RELEASE: prdata = {{(DATA_W-COEF_W){1'b0}}, release_reg};
            REG_GAMMA:   prdata = {{(DATA_W-GAMMA_W){1'b0}}, gamma_reg};
            REG_GAIN:    prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------- handshakes ----------------
    assign light.ready      = (state_reg == S_IDLE);
    assign in_xfer          = light.valid && light.ready;
    assign env.valid        = out_valid_reg;
    assign env.envelope_out = env_reg;
    assign out_load         = (state_reg == S_FIN) && (!out_valid_reg || env.ready);

    // ---------------- shared multiplier ----------------
    assign gamma_eff = (gamma_reg < GAMMA_MIN) ? GAMMA_MIN : gamma_reg;
    // x = exponent * 2^20 + 20 mantissa bits + offset; exponent is -shift
    assign x_val = $signed({-$signed({1'b0, shift_reg}), norm_reg[23:4]}) + MANT_OFFS;

    always_comb
    begin
        case (state_reg)
            S_TGT:
            begin
                mul_a = $signed({{(MUL_W-LIGHT_W){light_reg[LIGHT_W-1]}}, light_reg});
                mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, gain_reg});
            end
            S_STEP:
            begin
                mul_a = $signed({1'b0, d_reg});
                mul_b = $signed({1'b0, coef_reg});
            end
            S_POW:
            begin
                mul_a = x_val;
                mul_b = $signed({{(MUL_W-GAMMA_W){1'b0}}, gamma_eff});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ---------------- target and step ----------------
    assign light_pos = !light_reg[LIGHT_W-1] && (light_reg != '0);
    assign tgt_raw   = prod_reg[41:12];
    assign target    = !light_pos ? '0 :
                       (tgt_raw > {5'b0, Q24_ONE}) ? Q24_ONE : tgt_raw[LEVEL_W-1:0];
    assign level_c   = (level_reg > Q24_ONE) ? Q24_ONE : level_reg;
    assign up_c      = target > level_c;
    always_comb
    begin
        coef_c = up_c ? attack_reg : release_reg;
        if (coef_c > Q24_ONE)
            coef_c = Q24_ONE;
    end

    // rounded half up: (d * coef + 2^23) >> 24
    assign rnd_sum    = prod_reg[48:0] + ROUND_HALF;
    assign step       = rnd_sum[48:24];
    assign level_next = up_reg ? level_reg + step : level_reg - step;

    // ---------------- leading-one search: 16, 8, 4, 2, 1 ----------------
    assign amt = 5'd16 >> pass_reg;
    always_comb
    begin
        case (pass_reg)
            3'd0:    top_zero = (norm_reg[24:9] == '0);
            3'd1:    top_zero = (norm_reg[24:17] == '0);
            3'd2:    top_zero = (norm_reg[24:21] == '0);
            3'd3:    top_zero = (norm_reg[24:23] == '0);
            default: top_zero = !norm_reg[24];
        endcase
    end

    // ---------------- power word to Q0.16 ----------------
    assign acc      = {prod_reg[PROD_W-1], prod_reg} + POW_BIAS_Q16;
    assign exp_bits = acc[46:36];
    assign mant     = acc[35:16];
    assign sh_full  = EXP_SHIFT - exp_bits;
    assign shifted  = {1'b1, mant} >> sh_full[4:0];

    always_comb
    begin
        if (zero_reg || acc[PROD_W])
            env_next = '0;
        else if (exp_bits >= EXP_ONE)
            env_next = OUT_ONE;
        else if (exp_bits < EXP_FLOOR)
            env_next = '0;
        else
            env_next = shifted[ENV_W-1:0];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_xfer) state_next = S_TGT;
            S_TGT:  state_next = S_DIFF;
            S_DIFF: state_next = S_STEP;
            S_STEP: state_next = S_UPD;
            S_UPD:  state_next = (level_next == '0) ? S_FIN : S_NORM;
            S_NORM: if (pass_reg == LAST_PASS) state_next = S_POW;
            S_POW:  state_next = S_FIN;
            S_FIN:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DIFF)
                level_reg <= level_c;
            else if (state_reg == S_UPD)
                level_reg <= level_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (env.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        // power word must hold while the result waits for the output register
        if (state_reg != S_FIN)
            prod_reg <= mul_p;
        if (in_xfer)
            light_reg <= light.light_level;
        if (state_reg == S_DIFF)
        begin
            up_reg   <= up_c;
            coef_reg <= coef_c;
            d_reg    <= up_c ? target - level_c : level_c - target;
        end
        if (state_reg == S_UPD)
        begin
            norm_reg  <= level_next;
            zero_reg  <= (level_next == '0);
            shift_reg <= '0;
            pass_reg  <= '0;
        end
        if (state_reg == S_NORM)
        begin
            pass_reg <= pass_reg + 3'd1;
            if (top_zero)
            begin
                norm_reg  <= norm_reg << amt;
                shift_reg <= shift_reg + amt;
            end
        end
        if (out_load)
            env_reg <= env_next;
    end

    // ---------------- checks ----------------
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= Q24_ONE)
        else $error("smoothed level above 1.0");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == S_TGT)
        else $error("accepted sample did not start the sequence");

    a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POW |-> norm_reg[LEVEL_W-1])
        else $error("level not normalized before power step");

    a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> env_reg <= OUT_ONE)
        else $error("envelope above 1.0");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !env.ready |=> out_valid_reg && $stable(env_reg))
        else $error("pending result overwritten");

endmodule
